// ===== rtl/core/latency_percentile_rate_tracker_macros.svh =====
// assertion macros for the latency percentile and rate tracker
// no dependencies; included by the top level
`ifndef LATENCY_PERCENTILE_RATE_TRACKER_MACROS_SVH
`define LATENCY_PERCENTILE_RATE_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define LPRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lprt assertion failed");
`define LPRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lprt assertion failed");
`else
`define LPRT_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/lprt_pkg.sv =====
// shared constants and types of the latency percentile and rate tracker
// no dependencies
package lprt_pkg;
   localparam int WINDOW_DEF = 64;
   localparam int LAT_W      = 16;
   localparam int TIME_W     = 48;
   localparam int CONF_W     = 16;
   localparam int COUNT_W    = 32;
   localparam int RATE_W     = 28;
   localparam int DIV_W      = 48;

   localparam logic [RATE_W-1:0] RATE_MAX  = 28'hFFF_FFFF;
   localparam logic [CONF_W-1:0] CONF_ONE  = 16'd32768;
   localparam logic [14:0]       DECAY_Q15 = 15'd31130;
   localparam logic [DIV_W-1:0]  RATE_NUM  = 48'd256000000;
   // floor(x/5) as (x * ceil(2^34/5)) >> 34, exact for x below 2^34
   localparam logic [31:0]       RECIP_5   = 32'hCCCC_CCCD;
   localparam int                RECIP5_SH = 34;
   // floor(x/20) as (x * ceil(2^20/20)) >> 20
   localparam logic [15:0]       RECIP_20  = 16'd52429;
   localparam int                RECIP_SH  = 20;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RANK, ST_SELECT, ST_RATE_GO, ST_RATE,
      ST_AVG_GO, ST_AVG, ST_COMMIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic rank_init;
      logic div_start;
      logic div_avg;
      logic commit_avg;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic sel_done;
      logic div_done;
      logic rate_ok;
   } dp_status_type;
endpackage

// ===== rtl/core/lprt_if.sv =====
// request and response channel interfaces
// depends on lprt_pkg
interface lprt_req_if;
   logic                         valid;
   logic                         ready;
   logic [lprt_pkg::LAT_W-1:0]   lat_sample;
   logic [lprt_pkg::TIME_W-1:0]  timestamp_us;
   logic [lprt_pkg::CONF_W-1:0]  confidence;
   modport source (output valid, lat_sample, timestamp_us, confidence, input ready);
   modport sink (input valid, lat_sample, timestamp_us, confidence, output ready);
endinterface

interface lprt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lprt_pkg::COUNT_W-1:0] event_count;
   logic [lprt_pkg::LAT_W-1:0]   p95_lat;
   logic [lprt_pkg::RATE_W-1:0]  rate_q8;
   logic [lprt_pkg::CONF_W-1:0]  peak_confidence;
   modport source (output valid, event_count, p95_lat, rate_q8, peak_confidence,
                   input ready);
   modport sink (input valid, event_count, p95_lat, rate_q8, peak_confidence,
                 output ready);
endinterface

// ===== rtl/core/latency_percentile_rate_tracker.sv =====
// the response is published after the rank select over the n valid ring samples; a rate
// update adds a 48-step divide, an average by five and a commit
// one request in flight; the next request is taken the cycle after publish
// while the finished response waits in the output register
// reset: synchronous, active high; the ring needs no clearing, counters start at zero
module latency_percentile_rate_tracker #(
   parameter int WINDOW = lprt_pkg::WINDOW_DEF
) (
   input  logic clock,
   input  logic reset,
   lprt_req_if.sink   req,
   lprt_rsp_if.source rsp
);
   import lprt_pkg::*;
   `include "latency_percentile_rate_tracker_macros.svh"

   dp_cmd_type    cmd;
   dp_status_type status;

   lprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .status    (status),
      .cmd       (cmd)
   );

   lprt_dp #(.WINDOW(WINDOW)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .lat_sample      (req.lat_sample),
      .timestamp_us    (req.timestamp_us),
      .confidence      (req.confidence),
      .event_count     (rsp.event_count),
      .p95_lat         (rsp.p95_lat),
      .rate_q8         (rsp.rate_q8),
      .peak_confidence (rsp.peak_confidence)
   );

   `LPRT_ASSERT_NEXT(a_busy_after_req, clock, reset, req.valid && req.ready, !req.ready)
   `LPRT_ASSERT_SAME(a_publish_slot_free, clock, reset, cmd.publish, !rsp.valid || rsp.ready)
   `LPRT_ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp.valid)
endmodule

// ===== rtl/core/lprt_dp.sv =====
// datapath: latency ring, radix rank select, serial rate divider, average, peak decay
// depends on lprt_pkg
module lprt_dp #(
   parameter int WINDOW = lprt_pkg::WINDOW_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lprt_pkg::dp_cmd_type         cmd,
   output lprt_pkg::dp_status_type      status,
   input  logic [lprt_pkg::LAT_W-1:0]   lat_sample,
   input  logic [lprt_pkg::TIME_W-1:0]  timestamp_us,
   input  logic [lprt_pkg::CONF_W-1:0]  confidence,
   output logic [lprt_pkg::COUNT_W-1:0] event_count,
   output logic [lprt_pkg::LAT_W-1:0]   p95_lat,
   output logic [lprt_pkg::RATE_W-1:0]  rate_q8,
   output logic [lprt_pkg::CONF_W-1:0]  peak_confidence
);
   import lprt_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int X_W   = CNT_W + 5;
   localparam int P_W   = X_W + 16;
   localparam logic [CNT_W-1:0] WIN_N  = CNT_W'(WINDOW);
   localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW - 1);

   logic [LAT_W-1:0] ring [WINDOW];

   logic [IDX_W-1:0]   wpos_ff, wpos_in;
   logic [CNT_W-1:0]   vcnt_ff, vcnt_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0]  prev_ff, prev_in;
   logic [TIME_W-1:0]  dt_ff, dt_in;
   logic               rate_ok_ff, rate_ok_in;
   logic [RATE_W-1:0]  avg_ff, avg_in;
   logic [CONF_W-1:0]  peak_ff, peak_in;

   logic               sel_run_ff, sel_run_in;
   logic [LAT_W-1:0]   prefix_ff, prefix_in;
   logic [3:0]         bit_ff, bit_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   raddr_ff, raddr_in;
   logic               pend_ff, pend_in;
   logic [LAT_W-1:0]   rdata_ff;

   logic               div_run_ff, div_run_in;
   logic               avg_run_ff, avg_run_in;
   logic [5:0]         div_cnt_ff, div_cnt_in;
   logic [DIV_W-1:0]   num_ff, num_in;
   logic [DIV_W-1:0]   den_ff, den_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;

   logic [LAT_W-1:0]   out_p95_ff, out_p95_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [RATE_W-1:0]  out_rate_ff, out_rate_in;
   logic [CONF_W-1:0]  out_peak_ff, out_peak_in;

   logic [TIME_W-1:0]  diff;
   logic [CONF_W-1:0]  conf_sat;
   logic [30:0]        decay_prod;
   logic [X_W-1:0]     rank_x;
   logic [P_W-1:0]     rank_prod;
   logic               issue, pass_end, match;
   logic [16:0]        hi_mask;
   logic [DIV_W:0]     trial;
   logic [63:0]        avg_prod;
   logic               sel_done, div_done;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring[wpos_ff] <= lat_sample;
      end
      rdata_ff <= ring[raddr_ff[IDX_W-1:0]];
   end

   always_comb begin
      diff       = timestamp_us - prev_ff;
      conf_sat   = (confidence > CONF_ONE) ? CONF_ONE : confidence;
      decay_prod = 31'(peak_ff) * 31'(DECAY_Q15);
      rank_x     = X_W'(vcnt_ff) * X_W'(19);
      rank_prod  = P_W'(rank_x) * P_W'(RECIP_20);
      issue      = raddr_ff != vcnt_ff;
      pass_end   = !issue && !pend_ff;
      // bits above the one under test
      hi_mask    = 17'h1FFFF << ({1'b0, bit_ff} + 5'd1);
      match      = (((rdata_ff ^ prefix_ff) & hi_mask[15:0]) == '0) && !rdata_ff[bit_ff];
      trial      = {rem_ff, num_ff[DIV_W-1]};
      avg_prod   = 64'(num_ff[31:0]) * 64'(RECIP_5);
   end

   always_comb begin
      wpos_in = wpos_ff;  vcnt_in = vcnt_ff;  total_in = total_ff;
      prev_in = prev_ff;  dt_in = dt_ff;      rate_ok_in = rate_ok_ff;
      avg_in  = avg_ff;   peak_in = peak_ff;
      if (cmd.accept) begin
         wpos_in    = (wpos_ff == WIN_LAST) ? '0 : wpos_ff + 1'b1;
         vcnt_in    = (vcnt_ff == WIN_N) ? vcnt_ff : vcnt_ff + 1'b1;
         total_in   = total_ff + 1'b1;
         prev_in    = timestamp_us;
         dt_in      = diff;
         rate_ok_in = (prev_ff != '0) && (diff != '0) && !diff[TIME_W-1];
         peak_in    = (conf_sat > peak_ff) ? conf_sat : decay_prod[30:15];
      end
      if (cmd.commit_avg) begin
         avg_in = (num_ff > DIV_W'(RATE_MAX)) ? RATE_MAX : num_ff[RATE_W-1:0];
      end
   end

   always_comb begin
      sel_run_in = sel_run_ff; prefix_in = prefix_ff; bit_in = bit_ff;
      k_in = k_ff; cnt_in = cnt_ff; raddr_in = raddr_ff; pend_in = 1'b0;
      sel_done = 1'b0;
      if (cmd.rank_init) begin
         sel_run_in = 1'b1;
         prefix_in  = '0;
         bit_in     = 4'd15;
         k_in       = rank_prod[RECIP_SH +: IDX_W];
         cnt_in     = '0;
         raddr_in   = '0;
      end else if (sel_run_ff) begin
         pend_in = issue;
         if (issue) begin
            raddr_in = raddr_ff + 1'b1;
         end
         if (pend_ff && match) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (pass_end) begin
            if (CNT_W'(k_ff) >= cnt_ff) begin
               prefix_in[bit_ff] = 1'b1;
               k_in = IDX_W'(CNT_W'(k_ff) - cnt_ff);
            end
            cnt_in   = '0;
            raddr_in = '0;
            bit_in   = bit_ff - 4'd1;
            if (bit_ff == 4'd0) begin
               sel_run_in = 1'b0;
               sel_done   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      div_run_in = div_run_ff; div_cnt_in = div_cnt_ff; avg_run_in = 1'b0;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff;
      div_done = (div_run_ff && (div_cnt_ff == '0)) || avg_run_ff;
      if (cmd.div_start) begin
         if (cmd.div_avg) begin
            num_in     = DIV_W'({avg_ff, 2'b00}) + DIV_W'(num_ff[RATE_W-1:0]) + DIV_W'(2);
            avg_run_in = 1'b1;
         end else begin
            div_run_in = 1'b1;
            div_cnt_in = 6'(DIV_W - 1);
            rem_in     = '0;
            num_in     = RATE_NUM + (dt_ff >> 1);
            den_in     = dt_ff;
         end
      end else if (avg_run_ff) begin
         // the sum stays below 2^31, so the low word carries it
         num_in = DIV_W'(avg_prod[63:RECIP5_SH]);
      end else if (div_run_ff) begin
         // one restoring step per cycle, quotient shifts into num
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            num_in = {num_ff[DIV_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - 6'd1;
         if (div_cnt_ff == '0) begin
            div_run_in = 1'b0;
         end
      end
   end

   assign status = {sel_done, div_done, rate_ok_ff};

   always_comb begin
      out_p95_in = out_p95_ff; out_cnt_in = out_cnt_ff;
      out_rate_in = out_rate_ff; out_peak_in = out_peak_ff;
      if (cmd.publish) begin
         out_p95_in  = prefix_ff;
         out_cnt_in  = total_ff;
         out_rate_in = avg_ff;
         out_peak_in = peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;  vcnt_ff <= '0;  total_ff <= '0;  prev_ff <= '0;
         avg_ff <= '0;   peak_ff <= '0;  rate_ok_ff <= 1'b0;
         sel_run_ff <= 1'b0;  pend_ff <= 1'b0;  raddr_ff <= '0;
         div_run_ff <= 1'b0;  div_cnt_ff <= '0;  avg_run_ff <= 1'b0;
      end else begin
         wpos_ff <= wpos_in;  vcnt_ff <= vcnt_in;  total_ff <= total_in;
         prev_ff <= prev_in;  avg_ff <= avg_in;    peak_ff <= peak_in;
         rate_ok_ff <= rate_ok_in;
         sel_run_ff <= sel_run_in;  pend_ff <= pend_in;  raddr_ff <= raddr_in;
         div_run_ff <= div_run_in;  div_cnt_ff <= div_cnt_in;  avg_run_ff <= avg_run_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in;  prefix_ff <= prefix_in;  bit_ff <= bit_in;
      k_ff <= k_in;    cnt_ff <= cnt_in;
      num_ff <= num_in;  den_ff <= den_in;  rem_ff <= rem_in;
      out_p95_ff <= out_p95_in;  out_cnt_ff <= out_cnt_in;
      out_rate_ff <= out_rate_in;  out_peak_ff <= out_peak_in;
   end

   assign event_count     = out_cnt_ff;
   assign p95_lat         = out_p95_ff;
   assign rate_q8         = out_rate_ff;
   assign peak_confidence = out_peak_ff;
endmodule

// ===== rtl/core/lprt_ctrl.sv =====
// controller: sequences ring write, rank select, rate and average divisions
// depends on lprt_pkg
module lprt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  lprt_pkg::dp_status_type status,
   output lprt_pkg::dp_cmd_type    cmd
);
   import lprt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_RANK;
         ST_RANK:    state_in = ST_SELECT;
         ST_SELECT: begin
            if (status.sel_done) state_in = status.rate_ok ? ST_RATE_GO : ST_FINISH;
         end
         ST_RATE_GO: state_in = ST_RATE;
         ST_RATE:    if (status.div_done) state_in = ST_AVG_GO;
         ST_AVG_GO:  state_in = ST_AVG;
         ST_AVG:     if (status.div_done) state_in = ST_COMMIT;
         ST_COMMIT:  state_in = ST_FINISH;
         ST_FINISH:  if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_RANK:    cmd.rank_init = 1'b1;
         ST_RATE_GO: cmd.div_start = 1'b1;
         ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_avg   = 1'b1;
         end
         ST_COMMIT:  cmd.commit_avg = 1'b1;
         ST_FINISH:  cmd.publish = slot_free;
         default:    cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
